/* sv/ppcb_pkg.sv */
// ----------------------------------------------------------------------------
// Point pose transform and cube binner: shared definitions
// Types for the point and result transactions, register indexes, reset
// values and fixed-point constants of the transform and the cube binning.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppcb_pkg;

	// Default grid size in cubes.
	localparam int GRID_WIDTH_DEF  = 21;
	localparam int GRID_HEIGHT_DEF = 21;
	localparam int GRID_DEPTH_DEF  = 11;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_ROTATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_X       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_I      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_J      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_K      = 3'd6;
	localparam int CFG_DATA_W = 64;

	// Reset values: identity rotation, no translation, map origin in cube (10,10,5).
	localparam logic [63:0] POSE_ROTATION_RST = 64'h4000_0000_0000_0000;
	localparam logic signed [6:0] OFFSET_I_RST = 7'sd10;
	localparam logic signed [6:0] OFFSET_J_RST = 7'sd10;
	localparam logic signed [6:0] OFFSET_K_RST = 7'sd5;

	// Cycles the input is held off after reset or a register write, while the
	// rotation matrix is rebuilt.
	localparam logic [1:0] CFG_SETTLE = 2'd2;

	// Datapath widths.
	localparam int COORD_W = 32;
	localparam int VEC_W   = 33;  // point minus translation, kept exact
	localparam int M_W     = 34;  // Q28 matrix entry
	localparam int PP_W    = 51;  // matrix entry times a 17-bit slice
	localparam int SUM_W   = 53;
	localparam int TOT_W   = 70;
	localparam int ROT_W   = 42;  // rotated coordinate before translation
	localparam int ACC_W   = 43;  // rotated coordinate plus translation
	localparam int CUBE_W  = 13;
	localparam int IDX_W   = 10;  // signed cube index per axis

	localparam int Q28_SHIFT = 28;
	localparam logic signed [M_W-1:0]   ONE_Q28  = 34'sd268435456;
	localparam logic signed [TOT_W-1:0] Q28_HALF = 70'sd134217728;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 43'sd2147483647;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -43'sd2147483648;

	// The cube edge of 51200 units is 25 times 2^11: the magnitude is shifted
	// right by 11 and then divided by 25 through a reciprocal multiply, which is
	// exact below DIV_LIMIT. At or above DIV_LIMIT the quotient is clamped,
	// which is far outside any grid.
	localparam logic signed [VEC_W-1:0] HALF_CUBE = 33'sd25600;
	localparam int DIV_SHIFT   = 11;
	localparam int X_W         = 13;
	localparam int DIV_LIMIT   = 6400;
	localparam int RECIP_MULT  = 10486;
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_PW    = 27;
	localparam int QUO_W       = 8;
	localparam logic [QUO_W-1:0] QUO_MAX = 8'd255;

	typedef struct packed {
		logic                       cmd;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
		logic signed [COORD_W-1:0]  point_z;
		logic [31:0]                intensity_bits;
		logic                       point_class;
		logic                       last_in_cloud;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  out_x;
		logic signed [COORD_W-1:0]  out_y;
		logic signed [COORD_W-1:0]  out_z;
		logic [31:0]                intensity_out;
		logic [CUBE_W-1:0]          cube_index;
		logic                       in_grid;
		logic                       class_out;
		logic                       last_out;
	} result_t;

	// Command codes.
	localparam logic CMD_FORWARD = 1'b0;
	localparam logic CMD_INVERSE = 1'b1;

endpackage

`default_nettype wire

/* sv/point_pose_transform_cube_binner.sv */
// ----------------------------------------------------------------------------
// Point pose transform and cube binner
// Rotates each lidar point by a quaternion pose and translates it (or the
// inverse), then bins forward results into a grid of cubes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// The block takes one point per clock cycle while point_stall is low, and
// returns its result through an eight-stage pipeline that holds only when
// the result side stalls and closes up its own bubbles. The stages
// are: translation subtract, 18 partial products of a 34-bit matrix entry by
// a 17-bit coordinate slice, two sum stages with Q28 rounding, translation add
// with saturation, and three stages of cube binning. The rotation matrix is
// built from the quaternion register in two register steps, so after reset
// and after every register write the point input stalls while it is rebuilt.
// The configuration port is always ready.
module point_pose_transform_cube_binner #(
	parameter int GRID_WIDTH  = ppcb_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = ppcb_pkg::GRID_HEIGHT_DEF,
	parameter int GRID_DEPTH  = ppcb_pkg::GRID_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               point_valid,
	output logic                                    point_stall,
	input  wire ppcb_pkg::point_t                   point,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output ppcb_pkg::result_t                       result,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ppcb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ppcb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IW_I  = $clog2(GRID_WIDTH);
	localparam int IW_J  = $clog2(GRID_HEIGHT);
	localparam int IW_K  = $clog2(GRID_DEPTH);
	localparam int LIN_W = $clog2(GRID_WIDTH * GRID_HEIGHT * GRID_DEPTH);
	localparam int GRID_DIM [3] = '{GRID_WIDTH, GRID_HEIGHT, GRID_DEPTH};

	typedef struct packed {
		logic [31:0] intensity;
		logic        point_class;
		logic        last;
	} side_t;

	// Configuration registers.
	logic [63:0]                                 pose_rotation_q;
	logic signed [ppcb_pkg::COORD_W-1:0]         trans_q [3];
	logic signed [6:0]                           offset_q [3];
	logic [1:0]                                  settle_q;

	// Quaternion products and the rotation matrix.
	logic signed [15:0] qx, qy, qz, qw;
	logic signed [31:0] qxx_q, qyy_q, qzz_q, qxy_q, qxz_q, qyz_q, qxw_q, qyw_q, qzw_q;
	logic signed [ppcb_pkg::M_W-1:0] m_q [3][3];

	// Handshake.
	logic accept;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;

	// Pipeline payload.
	logic cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic signed [ppcb_pkg::VEC_W-1:0]   vec_s1 [3];
	logic signed [ppcb_pkg::PP_W-1:0]    plo_s2 [3][3];
	logic signed [ppcb_pkg::PP_W-1:0]    phi_s2 [3][3];
	logic signed [ppcb_pkg::SUM_W-1:0]   slo_s3 [3];
	logic signed [ppcb_pkg::SUM_W-1:0]   shi_s3 [3];
	logic signed [ppcb_pkg::ROT_W-1:0]   rot_s4 [3];
	logic signed [ppcb_pkg::COORD_W-1:0] out_s5 [3];
	logic signed [ppcb_pkg::COORD_W-1:0] out_s6 [3];
	logic signed [ppcb_pkg::COORD_W-1:0] out_s7 [3];
	logic signed [ppcb_pkg::COORD_W-1:0] out_s8 [3];
	logic [ppcb_pkg::X_W-1:0]            x_s6 [3];
	logic                                big_s6 [3];
	logic                                neg_s6 [3];
	logic signed [ppcb_pkg::IDX_W-1:0]   idx_s7 [3];
	logic                                inside_s7;
	logic [ppcb_pkg::CUBE_W-1:0]         cube_s8;
	logic                                inside_s8;

	// Combinational helpers.
	logic signed [ppcb_pkg::M_W-1:0]   coef_c [3][3];
	logic signed [16:0]                lo_c [3];
	logic signed [16:0]                hi_c [3];
	logic signed [ppcb_pkg::TOT_W-1:0] tot_c [3];
	logic signed [ppcb_pkg::ACC_W-1:0] acc_c [3];
	logic signed [ppcb_pkg::VEC_W-1:0] s_c [3];
	logic [ppcb_pkg::VEC_W-1:0]        mag_c [3];
	logic [ppcb_pkg::VEC_W-ppcb_pkg::DIV_SHIFT-1:0] xw_c [3];
	logic [ppcb_pkg::RECIP_PW-1:0]     recip_c [3];
	logic [ppcb_pkg::QUO_W-1:0]        quo_c [3];
	logic signed [ppcb_pkg::IDX_W-1:0] mag_idx_c [3];
	logic signed [ppcb_pkg::IDX_W-1:0] idx_c [3];
	logic                              axis_in_c [3];
	logic [LIN_W-1:0]                  lin_c;

	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_rotation_q <= ppcb_pkg::POSE_ROTATION_RST;
			trans_q[0]      <= '0;
			trans_q[1]      <= '0;
			trans_q[2]      <= '0;
			offset_q[0]     <= ppcb_pkg::OFFSET_I_RST;
			offset_q[1]     <= ppcb_pkg::OFFSET_J_RST;
			offset_q[2]     <= ppcb_pkg::OFFSET_K_RST;
			settle_q        <= ppcb_pkg::CFG_SETTLE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ppcb_pkg::REG_POSE_ROTATION: pose_rotation_q <= cfg_data;
					ppcb_pkg::REG_TRANS_X:       trans_q[0] <= signed'(cfg_data[31:0]);
					ppcb_pkg::REG_TRANS_Y:       trans_q[1] <= signed'(cfg_data[31:0]);
					ppcb_pkg::REG_TRANS_Z:       trans_q[2] <= signed'(cfg_data[31:0]);
					ppcb_pkg::REG_OFFSET_I:      offset_q[0] <= signed'(cfg_data[6:0]);
					ppcb_pkg::REG_OFFSET_J:      offset_q[1] <= signed'(cfg_data[6:0]);
					ppcb_pkg::REG_OFFSET_K:      offset_q[2] <= signed'(cfg_data[6:0]);
					default: ;
				endcase
				settle_q <= ppcb_pkg::CFG_SETTLE;
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Rotation matrix in Q28, rebuilt from the quaternion every cycle
	// ------------------------------------------------------------------------
	assign qx = signed'(pose_rotation_q[15:0]);
	assign qy = signed'(pose_rotation_q[31:16]);
	assign qz = signed'(pose_rotation_q[47:32]);
	assign qw = signed'(pose_rotation_q[63:48]);

	always_ff @(posedge clk) begin
		qxx_q <= qx * qx;
		qyy_q <= qy * qy;
		qzz_q <= qz * qz;
		qxy_q <= qx * qy;
		qxz_q <= qx * qz;
		qyz_q <= qy * qz;
		qxw_q <= qx * qw;
		qyw_q <= qy * qw;
		qzw_q <= qz * qw;
	end

	always_ff @(posedge clk) begin
		m_q[0][0] <= ppcb_pkg::ONE_Q28 - ((34'(qyy_q) + 34'(qzz_q)) <<< 1);
		m_q[0][1] <= (34'(qxy_q) - 34'(qzw_q)) <<< 1;
		m_q[0][2] <= (34'(qxz_q) + 34'(qyw_q)) <<< 1;
		m_q[1][0] <= (34'(qxy_q) + 34'(qzw_q)) <<< 1;
		m_q[1][1] <= ppcb_pkg::ONE_Q28 - ((34'(qxx_q) + 34'(qzz_q)) <<< 1);
		m_q[1][2] <= (34'(qyz_q) - 34'(qxw_q)) <<< 1;
		m_q[2][0] <= (34'(qxz_q) - 34'(qyw_q)) <<< 1;
		m_q[2][1] <= (34'(qyz_q) + 34'(qxw_q)) <<< 1;
		m_q[2][2] <= ppcb_pkg::ONE_Q28 - ((34'(qxx_q) + 34'(qyy_q)) <<< 1);
	end

	// ------------------------------------------------------------------------
	// Handshake: a stage loads when it is empty or the next stage loads
	// ------------------------------------------------------------------------
	assign rdy_s8 = !valid_s8 || !result_stall;
	assign rdy_s7 = !valid_s7 || rdy_s8;
	assign rdy_s6 = !valid_s6 || rdy_s7;
	assign rdy_s5 = !valid_s5 || rdy_s6;
	assign rdy_s4 = !valid_s4 || rdy_s5;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign point_stall = !rdy_s1 || (settle_q != '0);
	assign accept      = point_valid && !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= accept;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
			if (rdy_s6) valid_s6 <= valid_s5;
			if (rdy_s7) valid_s7 <= valid_s6;
			if (rdy_s8) valid_s8 <= valid_s7;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: the inverse command subtracts the translation first
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			cmd_s1  <= point.cmd;
			side_s1 <= '{intensity: point.intensity_bits, point_class: point.point_class,
				last: point.last_in_cloud};
			if (point.cmd == ppcb_pkg::CMD_INVERSE) begin
				vec_s1[0] <= 33'(point.point_x) - 33'(trans_q[0]);
				vec_s1[1] <= 33'(point.point_y) - 33'(trans_q[1]);
				vec_s1[2] <= 33'(point.point_z) - 33'(trans_q[2]);
			end else begin
				vec_s1[0] <= 33'(point.point_x);
				vec_s1[1] <= 33'(point.point_y);
				vec_s1[2] <= 33'(point.point_z);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 2: partial products. The inverse uses the transposed matrix.
	// ------------------------------------------------------------------------
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo_c[a] = signed'({1'b0, vec_s1[a][15:0]});
			hi_c[a] = vec_s1[a][32:16];
			for (int n = 0; n < 3; n++) begin
				coef_c[a][n] = (cmd_s1 == ppcb_pkg::CMD_INVERSE) ? m_q[n][a] : m_q[a][n];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			cmd_s2  <= cmd_s1;
			side_s2 <= side_s1;
			for (int a = 0; a < 3; a++) begin
				for (int n = 0; n < 3; n++) begin
					plo_s2[a][n] <= ppcb_pkg::PP_W'(coef_c[a][n]) * ppcb_pkg::PP_W'(lo_c[n]);
					phi_s2[a][n] <= ppcb_pkg::PP_W'(coef_c[a][n]) * ppcb_pkg::PP_W'(hi_c[n]);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 3: sums of the low and high partial products
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			cmd_s3  <= cmd_s2;
			side_s3 <= side_s2;
			for (int a = 0; a < 3; a++) begin
				slo_s3[a] <= ppcb_pkg::SUM_W'(plo_s2[a][0]) + ppcb_pkg::SUM_W'(plo_s2[a][1])
					+ ppcb_pkg::SUM_W'(plo_s2[a][2]);
				shi_s3[a] <= ppcb_pkg::SUM_W'(phi_s2[a][0]) + ppcb_pkg::SUM_W'(phi_s2[a][1])
					+ ppcb_pkg::SUM_W'(phi_s2[a][2]);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 4: exact total, rounded half up out of Q28
	// ------------------------------------------------------------------------
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			tot_c[a] = (ppcb_pkg::TOT_W'(shi_s3[a]) <<< 16) + ppcb_pkg::TOT_W'(slo_s3[a])
				+ ppcb_pkg::Q28_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			cmd_s4  <= cmd_s3;
			side_s4 <= side_s3;
			for (int a = 0; a < 3; a++) begin
				rot_s4[a] <= tot_c[a][ppcb_pkg::TOT_W-1:ppcb_pkg::Q28_SHIFT];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 5: translation add for the forward command, then saturation
	// ------------------------------------------------------------------------
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (cmd_s4 == ppcb_pkg::CMD_FORWARD) begin
				acc_c[a] = ppcb_pkg::ACC_W'(rot_s4[a]) + ppcb_pkg::ACC_W'(trans_q[a]);
			end else begin
				acc_c[a] = ppcb_pkg::ACC_W'(rot_s4[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			cmd_s5  <= cmd_s4;
			side_s5 <= side_s4;
			for (int a = 0; a < 3; a++) begin
				if (acc_c[a] > ppcb_pkg::SAT_MAX) begin
					out_s5[a] <= ppcb_pkg::SAT_MAX[ppcb_pkg::COORD_W-1:0];
				end else if (acc_c[a] < ppcb_pkg::SAT_MIN) begin
					out_s5[a] <= ppcb_pkg::SAT_MIN[ppcb_pkg::COORD_W-1:0];
				end else begin
					out_s5[a] <= acc_c[a][ppcb_pkg::COORD_W-1:0];
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 6: shift to the cube corner, take the magnitude, divide by 2^11
	// ------------------------------------------------------------------------
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			s_c[a]   = ppcb_pkg::VEC_W'(out_s5[a]) + ppcb_pkg::HALF_CUBE;
			mag_c[a] = s_c[a][ppcb_pkg::VEC_W-1] ? unsigned'(-s_c[a]) : unsigned'(s_c[a]);
			xw_c[a]  = mag_c[a][ppcb_pkg::VEC_W-1:ppcb_pkg::DIV_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			cmd_s6  <= cmd_s5;
			side_s6 <= side_s5;
			for (int a = 0; a < 3; a++) begin
				out_s6[a] <= out_s5[a];
				neg_s6[a] <= s_c[a][ppcb_pkg::VEC_W-1];
				big_s6[a] <= xw_c[a] >= (ppcb_pkg::VEC_W - ppcb_pkg::DIV_SHIFT)'(ppcb_pkg::DIV_LIMIT);
				x_s6[a]   <= xw_c[a][ppcb_pkg::X_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 7: divide by 25, apply the sign rule and the center offset
	// ------------------------------------------------------------------------
	// A negative sum gives the truncated quotient minus one, which for an
	// exact multiple of the cube edge is one cube lower than the floor.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			recip_c[a] = ppcb_pkg::RECIP_PW'(x_s6[a])
				* ppcb_pkg::RECIP_PW'(ppcb_pkg::RECIP_MULT);
			quo_c[a] = big_s6[a] ? ppcb_pkg::QUO_MAX
				: recip_c[a][ppcb_pkg::RECIP_SHIFT +: ppcb_pkg::QUO_W];
			mag_idx_c[a] = signed'(ppcb_pkg::IDX_W'(quo_c[a]));
			idx_c[a] = (neg_s6[a] ? (-mag_idx_c[a] - 10'sd1) : mag_idx_c[a])
				+ ppcb_pkg::IDX_W'(offset_q[a]);
			axis_in_c[a] = (idx_c[a] >= 10'sd0)
				&& (idx_c[a] < signed'(ppcb_pkg::IDX_W'(GRID_DIM[a])));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			side_s7   <= side_s6;
			inside_s7 <= (cmd_s6 == ppcb_pkg::CMD_FORWARD)
				&& axis_in_c[0] && axis_in_c[1] && axis_in_c[2];
			for (int a = 0; a < 3; a++) begin
				out_s7[a] <= out_s6[a];
				idx_s7[a] <= idx_c[a];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 8: linear cube index, result register
	// ------------------------------------------------------------------------
	assign lin_c = LIN_W'(idx_s7[0][IW_I-1:0])
		+ LIN_W'(GRID_WIDTH) * LIN_W'(idx_s7[1][IW_J-1:0])
		+ LIN_W'(GRID_WIDTH * GRID_HEIGHT) * LIN_W'(idx_s7[2][IW_K-1:0]);

	always_ff @(posedge clk) begin
		if (rdy_s8) begin
			side_s8   <= side_s7;
			inside_s8 <= inside_s7;
			cube_s8   <= inside_s7 ? ppcb_pkg::CUBE_W'(lin_c) : '0;
			for (int a = 0; a < 3; a++) begin
				out_s8[a] <= out_s7[a];
			end
		end
	end

	assign result_valid         = valid_s8;
	assign result.out_x         = out_s8[0];
	assign result.out_y         = out_s8[1];
	assign result.out_z         = out_s8[2];
	assign result.intensity_out = side_s8.intensity;
	assign result.cube_index    = cube_s8;
	assign result.in_grid       = inside_s8;
	assign result.class_out     = side_s8.point_class;
	assign result.last_out      = side_s8.last;

endmodule

`default_nettype wire

/* sv/ppcb_checker.sv */
// ----------------------------------------------------------------------------
// Point pose transform and cube binner: port checker
// Watches the ports of the top level and flags handshake and result slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppcb_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              point_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire ppcb_pkg::result_t result,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready
);

	// A stalled result transaction holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Points outside the grid, and inverse results, carry a zero cube index.
	a_cube_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.in_grid |-> result.cube_index == '0)
		else $error("cube index set outside the grid");

	// The point input holds off while the rotation matrix is rebuilt.
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> point_stall)
		else $error("point accepted right after a register write");

endmodule

bind point_pose_transform_cube_binner ppcb_checker u_ppcb_checker (.*);

`default_nettype wire
